### sv/gss_pkg.sv
package gss_pkg;

  localparam logic [1:0] FUNC_EVAL  = 2'd0;
  localparam logic [1:0] FUNC_MACH  = 2'd1;
  localparam logic [1:0] FUNC_ALT   = 2'd2;
  localparam logic [1:0] FUNC_GRID  = 2'd3;

  localparam logic [2:0] REG_KNEE_ONE   = 3'd0;
  localparam logic [2:0] REG_KNEE_TWO   = 3'd1;
  localparam logic [2:0] REG_KNEE_THREE = 3'd2;
  localparam logic [2:0] REG_KNEE_FOUR  = 3'd3;
  localparam logic [2:0] REG_LOW_END    = 3'd4;
  localparam logic [2:0] REG_HIGH_END   = 3'd5;
  localparam logic [2:0] REG_OFFSET     = 3'd6;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return S32_MAX;
    else if (v < -66'sd2147483648) return S32_MIN;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return sat64(s);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return sat64(s);
  endfunction

endpackage

### sv/gain_scheduled_stick_shaper.sv
// write words are taken without leaving the idle state; an evaluate word runs a
// breakpoint search on each axis, five divisions on one shared restoring divider
// and table reads, products and sequencing before its result is valid; a Mach number
// over the limit skips these and gives a zero result with mach_over_limit set
// throughput: one word at a time, not ready until the result is taken
// reset: synchronous active-low rst_n restores the knee, end and offset registers; tables
// are not cleared and must be written before evaluating
module gain_scheduled_stick_shaper
  import gss_pkg::*;
#(
  parameter int MACH_POINTS = 8,
  parameter int ALT_POINTS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func, row_index, column_index, table_word, stick_force, altitude_in, mach_number
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // shaped_gain
  output logic [31:0]  out_tdata,
  // mach_over_limit
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int MW = $clog2(MACH_POINTS);
  localparam int AW = $clog2(ALT_POINTS);
  localparam int GD = MACH_POINTS * ALT_POINTS;
  localparam int GW = $clog2(GD);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MSRCH = 5'd1;
  localparam logic [4:0] S_ASRCH = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_GRD   = 5'd4;
  localparam logic [4:0] S_L1    = 5'd5;
  localparam logic [4:0] S_L1D   = 5'd6;
  localparam logic [4:0] S_L2    = 5'd7;
  localparam logic [4:0] S_L2D   = 5'd8;
  localparam logic [4:0] S_L3    = 5'd9;
  localparam logic [4:0] S_L3D   = 5'd10;
  localparam logic [4:0] S_P2    = 5'd11;
  localparam logic [4:0] S_P3    = 5'd12;
  localparam logic [4:0] S_K1    = 5'd13;
  localparam logic [4:0] S_K1D   = 5'd14;
  localparam logic [4:0] S_K3D   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd18;
  localparam logic [4:0] S_WAIT1 = 5'd19;
  localparam logic [4:0] S_WAIT2 = 5'd20;
  localparam logic [4:0] S_WAIT3 = 5'd21;

  logic [1:0]         f_func;
  logic [3:0]         f_row, f_col;
  logic signed [31:0] f_word, f_force, f_alt, f_mach;
  assign f_func  = in_tdata[1:0];
  assign f_row   = in_tdata[5:2];
  assign f_col   = in_tdata[9:6];
  assign f_word  = in_tdata[41:10];
  assign f_force = in_tdata[73:42];
  assign f_alt   = in_tdata[105:74];
  assign f_mach  = in_tdata[137:106];

  logic signed [31:0] k1_r, k2_r, k3_r, k4_r, lo_r, hi_r, off_r;

  logic signed [31:0] mbp [MACH_POINTS];
  logic signed [31:0] abp [ALT_POINTS];
  logic signed [31:0] grid [GD];

  logic [4:0]  st_r;
  logic [4:0]  cnt_r;
  logic [MW-1:0] b_r;
  logic [AW-1:0] a_r;
  logic        bf_r, af_r;
  logic signed [31:0] force_r, alt_r, mach_r;
  logic signed [31:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [31:0] z11_r, z12_r, z21_r, z22_r;
  logic signed [31:0] t1_r, t2_r, s_r, p2_r, p3_r, kk1_r, res_r;
  logic        ovl_r;
  logic signed [31:0] ma_r, mb_r;
  logic signed [63:0] prod;
  logic [GW-1:0] g_addr_r;
  logic signed [31:0] g_q_r;
  logic signed [31:0] mach_last_r;

  div_req_t dreq;
  div_rsp_t drsp;
  logic               div_go_r;
  logic signed [63:0] dnum_r;
  logic signed [31:0] dden_r;

  always_comb begin
    dreq.start = div_go_r;
    dreq.num = dnum_r;
    dreq.den = dden_r;
  end

  gss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  gss_mul u_mul (.clk(clk), .a(ma_r), .b(mb_r), .p(prod));

  assign in_tready  = (st_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = res_r;
  assign out_tuser  = ovl_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= -32'sd196608; k2_r <= -32'sd65536; k3_r <= 32'sd65536;
      k4_r <= 32'sd196608; lo_r <= -32'sd196608; hi_r <= 32'sd196608;
      off_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KNEE_ONE:   k1_r <= cfg_data;
        REG_KNEE_TWO:   k2_r <= cfg_data;
        REG_KNEE_THREE: k3_r <= cfg_data;
        REG_KNEE_FOUR:  k4_r <= cfg_data;
        REG_LOW_END:    lo_r <= cfg_data;
        REG_HIGH_END:   hi_r <= cfg_data;
        REG_OFFSET:     off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && f_func == FUNC_MACH && 32'(f_col) < MACH_POINTS)
      mbp[f_col[MW-1:0]] <= f_word;
    if (in_acc && f_func == FUNC_ALT && 32'(f_row) < ALT_POINTS)
      abp[f_row[AW-1:0]] <= f_word;
    if (in_acc && f_func == FUNC_GRID && 32'(f_row) < ALT_POINTS
        && 32'(f_col) < MACH_POINTS)
      grid[GW'(32'(f_row) * MACH_POINTS + 32'(f_col))] <= f_word;
    g_q_r <= grid[g_addr_r];
    mach_last_r <= mbp[MW'(MACH_POINTS - 1)];
  end

  // helpers
  logic signed [31:0] sc_m, sc_a;
  assign sc_m = mbp[cnt_r[MW-1:0]];
  assign sc_a = abp[cnt_r[AW-1:0]];

  logic signed [31:0] qm;
  assign qm = sat64(66'(prod >>> 16));

  logic signed [31:0] xc, yc;
  always_comb begin
    if (mach_r < x1_r) xc = x1_r;
    else if (mach_r > x2_r) xc = x2_r;
    else xc = mach_r;
    if (alt_r < y1_r) yc = y1_r;
    else if (alt_r > y2_r) yc = y2_r;
    else yc = alt_r;
  end

  logic signed [32:0] p23;
  assign p23 = 33'(p2_r) + 33'(p3_r);

  // division start pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= (st_r == S_L1) || (st_r == S_L2) || (st_r == S_P3)
                  || ((st_r == S_L1D || st_r == S_K1D) && drsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovl_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_acc) begin
          force_r <= f_force; alt_r <= f_alt; mach_r <= f_mach;
          if (f_func == FUNC_EVAL) st_r <= S_WAIT1;
        end
        S_WAIT1: begin
          if (mach_r > mach_last_r) begin
            res_r <= '0; ovl_r <= 1'b1; st_r <= S_OUT;
          end else begin
            ovl_r <= 1'b0; cnt_r <= '0; bf_r <= 1'b0; st_r <= S_MSRCH;
          end
        end
        S_MSRCH: begin
          if (!bf_r) begin
            if (cnt_r == 5'd0 && sc_m > mach_r) begin
              b_r <= MW'(1); bf_r <= 1'b1;
            end else if (cnt_r != 5'd0 && sc_m > mach_r) begin
              b_r <= cnt_r[MW-1:0]; bf_r <= 1'b1;
            end else if (32'(cnt_r) >= MACH_POINTS - 2) begin
              b_r <= MW'(MACH_POINTS - 1); bf_r <= 1'b1;
            end
          end
          if (bf_r || 32'(cnt_r) >= MACH_POINTS - 2) begin
            cnt_r <= '0; af_r <= 1'b0; st_r <= S_ASRCH;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_ASRCH: begin
          if (!af_r) begin
            if (cnt_r == 5'd0 && sc_a > alt_r) begin
              a_r <= AW'(1); af_r <= 1'b1;
            end else if (cnt_r != 5'd0 && sc_a > alt_r) begin
              a_r <= cnt_r[AW-1:0]; af_r <= 1'b1;
            end else if (32'(cnt_r) >= ALT_POINTS - 2) begin
              a_r <= AW'(ALT_POINTS - 1); af_r <= 1'b1;
            end
          end
          if (af_r || 32'(cnt_r) >= ALT_POINTS - 2) begin
            cnt_r <= '0; st_r <= S_RDB;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_RDB: begin
          x1_r <= mbp[b_r - MW'(1)]; x2_r <= mbp[b_r];
          y1_r <= abp[a_r - AW'(1)]; y2_r <= abp[a_r];
          g_addr_r <= GW'(32'(a_r - AW'(1)) * MACH_POINTS + 32'(b_r) - 1);
          cnt_r <= '0; st_r <= S_GRD;
        end
        S_GRD: begin
          cnt_r <= cnt_r + 5'd1;
          case (cnt_r)
            5'd0: g_addr_r <= g_addr_r + GW'(1);
            5'd1: begin
              z11_r <= g_q_r;
              g_addr_r <= GW'(32'(a_r) * MACH_POINTS + 32'(b_r) - 1);
            end
            5'd2: begin z12_r <= g_q_r; g_addr_r <= g_addr_r + GW'(1); end
            5'd3: begin
              z21_r <= g_q_r;
              ma_r <= sub_sat(xc, x1_r); mb_r <= sub_sat(z12_r, z11_r);
            end
            default: begin
              z22_r <= g_q_r;
              cnt_r <= '0; st_r <= S_L1;
            end
          endcase
        end
        S_L1: begin
          dnum_r <= prod; dden_r <= sub_sat(x2_r, x1_r);
          ma_r <= sub_sat(xc, x1_r); mb_r <= sub_sat(z22_r, z21_r);
          st_r <= S_L1D;
        end
        S_L1D: if (drsp.done) begin
          t1_r <= add_sat(z11_r, drsp.quo);
          dnum_r <= prod; dden_r <= sub_sat(x2_r, x1_r);
          st_r <= S_L2D;
        end
        S_L2D: if (drsp.done) begin
          t2_r <= add_sat(z21_r, drsp.quo);
          ma_r <= sub_sat(yc, y1_r); mb_r <= sub_sat(add_sat(z21_r, drsp.quo), t1_r);
          st_r <= S_WAIT2;
        end
        S_WAIT2: st_r <= S_L2;
        S_L2: begin
          dnum_r <= prod; dden_r <= sub_sat(y2_r, y1_r);
          st_r <= S_L3D;
        end
        S_L3D: if (drsp.done) begin
          s_r <= add_sat(t1_r, drsp.quo);
          ma_r <= add_sat(t1_r, drsp.quo); mb_r <= k2_r;
          st_r <= S_L3;
        end
        S_L3: begin
          ma_r <= s_r; mb_r <= k3_r; st_r <= S_P2;
        end
        S_P2: begin
          p2_r <= add_sat(qm, off_r);
          ma_r <= s_r; mb_r <= force_r;
          st_r <= S_P3;
        end
        S_P3: begin
          p3_r <= add_sat(qm, off_r);
          dnum_r <= 64'(sub_sat(p2_r, lo_r)) <<< 16;
          dden_r <= sub_sat(k2_r, k1_r);
          st_r <= S_K1;
        end
        S_K1: begin
          t1_r <= qm;
          st_r <= S_K1D;
        end
        S_K1D: if (drsp.done) begin
          kk1_r <= drsp.quo;
          dnum_r <= 64'(sub_sat(hi_r, p3_r)) <<< 16;
          dden_r <= sub_sat(k4_r, k3_r);
          st_r <= S_K3D;
        end
        S_K3D: if (drsp.done) begin
          if (force_r < k2_r) begin
            ma_r <= kk1_r; mb_r <= sub_sat(force_r, k2_r);
          end else begin
            ma_r <= drsp.quo; mb_r <= sub_sat(force_r, k3_r);
          end
          st_r <= S_WAIT3;
        end
        S_WAIT3: st_r <= S_FIN;
        S_FIN: begin
          if (force_r < k2_r) begin
            if (force_r < k1_r) res_r <= lo_r;
            else res_r <= add_sat(qm, p2_r);
          end else if (force_r <= k3_r) begin
            res_r <= sat64(66'(t1_r) + 66'(p23 >>> 1));
          end else if (force_r > k4_r) begin
            res_r <= hi_r;
          end else begin
            res_r <= add_sat(qm, p3_r);
          end
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> !in_tready) else $error("input ready during division");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_ovl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0) else $error("over-limit gain");

endmodule

### sv/gss_div.sv
module gss_div
  import gss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [1:0]  nsgn_r, nsgn_nxt;
  logic [64:0] trial;
  logic [63:0] rs;
  logic signed [65:0] sq;

  assign rs = {rem_r[62:0], quo_r[63]};
  assign trial = {1'b0, rs} - {33'd0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    zero_nxt = zero_r;
    nsgn_nxt = nsgn_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      rem_nxt = '0;
      quo_nxt = req.num[63] ? 64'(-req.num) : 64'(req.num);
      den_nxt = req.den[31] ? 32'(-req.den) : 32'(req.den);
      neg_nxt = req.num[63] ^ req.den[31];
      zero_nxt = (req.den == '0);
      nsgn_nxt = (req.num == '0) ? 2'd0 : (req.num[63] ? 2'd2 : 2'd1);
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rs;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
    nsgn_r <= nsgn_nxt;
  end

  assign sq = neg_r ? -66'({2'b00, quo_r}) : 66'({2'b00, quo_r});

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (zero_r) begin
      case (nsgn_r)
        2'd1:    rsp.quo = S32_MAX;
        2'd2:    rsp.quo = S32_MIN;
        default: rsp.quo = '0;
      endcase
    end else begin
      rsp.quo = sat64(sq);
    end
  end

endmodule

### sv/gss_mul.sv
module gss_mul
  import gss_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
